>>> rtl/slot_handle_allocator_compacting_core_defines.svh
// Assertion macros for the slot handle allocator.
// Include-guarded; used by the port checker only.
`ifndef SLOT_HANDLE_ALLOCATOR_COMPACTING_CORE_DEFINES_SVH
`define SLOT_HANDLE_ALLOCATOR_COMPACTING_CORE_DEFINES_SVH
// implication checked every clock unless reset
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/sha_pkg.sv
// Package for the slot handle allocator: widths, request and status codes.
// No dependencies.
package sha_pkg;
   localparam int CAPACITY_DEF     = 64;
   localparam int HANDLE_WIDTH_DEF = 16;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 3;
   localparam int THR_W    = 9;
   localparam int OBJ_W    = 16;
   localparam int SLOT_W   = 6;
   localparam int CNT_W    = 7;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC = 3'd0, REQ_FREE = 3'd1, REQ_ACT = 3'd2, REQ_DEACT = 3'd3,
      REQ_QUERY = 3'd4, REQ_COMPACT = 3'd5, REQ_RSV6 = 3'd6, REQ_RSV7 = 3'd7
   } req_type_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 3'd0, ST_INVALID = 3'd1, ST_UNKNOWN = 3'd2, ST_NOT_ALLOC = 3'd3,
      ST_NO_CHANGE = 3'd4, ST_FULL = 3'd5, ST_CORRUPT = 3'd6, ST_RSV7 = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_APPLY, S_COMPACT, S_LOOK, S_FINAL
   } state_type;

   // control from sequencer to chain of cells
   typedef struct packed {
      logic search;    // compare key against every cell
      logic write_new; // load a fresh entry into addressed cell
      logic set_live;
      logic clr_live;
      logic set_on;
      logic clr_on;
      logic shift;     // one compaction step
      logic clear_all; // drop mappings beyond write pointer
   } cell_ctl_type;
endpackage

>>> rtl/sha_if.sv
// Valid/ready channel interface carrying a parameterized payload type.
// Depends on nothing.
interface sha_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sha_cell.sv
// One slot cell: handle, mapped/live/on bits, match flag, compaction shift.
// Depends on sha_pkg.
module sha_cell import sha_pkg::*; #(
   parameter int HW = HANDLE_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic          sel,      // this cell is addressed
   input  logic          keep,     // cell index below compaction bound
   input  logic [HW-1:0] key,
   input  logic [HW-1:0] wr_handle,
   // compaction: take neighbor's content when shifting
   input  logic [HW-1:0] nb_handle,
   input  logic          nb_mapped,
   input  logic          nb_live,
   input  logic          nb_on,
   input  logic          do_shift, // this cell takes from neighbor
   output logic [HW-1:0] handle,
   output logic          mapped,
   output logic          live,
   output logic          on,
   output logic          hit
);
   logic [HW-1:0] handle_ff;
   logic mapped_ff, live_ff, on_ff, hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift && do_shift) begin
         handle_ff <= nb_handle;
      end else if (ctl.write_new && sel) begin
         handle_ff <= wr_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= 1'b0; live_ff <= 1'b0; on_ff <= 1'b0; hit_ff <= 1'b0;
      end else begin
         if (ctl.search) begin
            hit_ff <= mapped_ff && (handle_ff == key) && (key != '0);
         end
         if (ctl.shift && do_shift) begin
            mapped_ff <= nb_mapped; live_ff <= nb_live; on_ff <= nb_on;
         end else if (ctl.clear_all && !keep) begin
            mapped_ff <= 1'b0; live_ff <= 1'b0; on_ff <= 1'b0;
         end else if (sel) begin
            if (ctl.write_new) mapped_ff <= 1'b1;
            if (ctl.set_live) live_ff <= 1'b1;
            if (ctl.clr_live) live_ff <= 1'b0;
            if (ctl.set_on) on_ff <= 1'b1;
            if (ctl.clr_on) on_ff <= 1'b0;
         end
      end
   end

   assign handle = handle_ff;
   assign mapped = mapped_ff;
   assign live   = live_ff;
   assign on     = on_ff;
   assign hit    = hit_ff;
endmodule

>>> rtl/sha_chain.sv
// Row of slot cells with neighbor links for compaction and a match encoder.
// Depends on sha_pkg and sha_cell.
module sha_chain import sha_pkg::*; #(
   parameter int CAP = CAPACITY_DEF,
   parameter int HW  = HANDLE_WIDTH_DEF,
   localparam int IW = $clog2(CAP)
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic [IW-1:0] addr,
   input  logic [IW:0]   bound,     // compaction keep bound
   input  logic [IW-1:0] hole,      // compaction: cells at and above shift down
   input  logic [HW-1:0] key,
   input  logic [HW-1:0] wr_handle,
   output logic          found,
   output logic [IW-1:0] found_idx,
   output logic          sel_live,
   output logic          sel_on
);
   logic [HW-1:0] h   [CAP];
   logic [CAP-1:0] m, l, o, hit;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [HW-1:0] nbh;
      logic nbm, nbl, nbo;
      if (i == CAP-1) begin : g_last
         assign nbh = '0; assign nbm = 1'b0; assign nbl = 1'b0; assign nbo = 1'b0;
      end else begin : g_mid
         assign nbh = h[i+1]; assign nbm = m[i+1]; assign nbl = l[i+1];
         assign nbo = o[i+1];
      end
      sha_cell #(.HW(HW)) u_cell (
         .clock, .reset, .ctl,
         .sel(addr == IW'(i)),
         .keep((IW+1)'(i) < bound),
         .key, .wr_handle,
         .nb_handle(nbh), .nb_mapped(nbm), .nb_live(nbl), .nb_on(nbo),
         .do_shift(IW'(i) >= hole),
         .handle(h[i]), .mapped(m[i]), .live(l[i]), .on(o[i]), .hit(hit[i])
      );
   end

   always_comb begin
      found = |hit;
      found_idx = '0;
      for (int i = CAP-1; i >= 0; i--) begin
         if (hit[i]) found_idx = IW'(i);
      end
   end

   assign sel_live   = l[addr];
   assign sel_on     = o[addr];
endmodule

>>> rtl/slot_handle_allocator_compacting_core.sv
// Top level of the slot handle allocator: sequencer, counters, reuse stack.
// Depends on sha_pkg, sha_if, sha_chain (and sha_cell below it).
//
//  channel  | dir | payload
//  req_     | in  | req_type, obj_handle
//  rsp_     | out | status, result_handle, slot_index, is_allocated, is_active,
//           |     | active_count, compacted
//  csr_     | in  | compact_threshold (9 bits)
//
// A request beat walks search, apply, result search and final read in that
// order; the result beat goes valid after the final read. A compaction
// visits each slot below used_slots at its start, then clears. The request
// side stalls from accept until the result beat is taken, so a new beat is
// accepted only after the previous result has been taken.
// Reset is synchronous and clears control, valid bits and counters.
module slot_handle_allocator_compacting_core import sha_pkg::*; #(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   sha_if.sink   req,
   sha_if.source rsp,
   sha_if.sink   csr
);
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = IW + 1;
   localparam int PW = CW + THR_W;

   state_type state_ff, state_in;
   cell_ctl_type ctl;

   logic [THR_W-1:0]  thr_ff;
   req_type_type      rq_ff;
   logic [HANDLE_WIDTH-1:0] h_ff, h_in;
   status_type st_ff, st_in;
   logic comp_ff, comp_in;
   logic [CW-1:0] used_ff, used_in, freed_ff, freed_in, depth_ff, depth_in;
   logic [CW-1:0] on_ff, on_in, rd_ff, rd_in;
   logic [HANDLE_WIDTH-1:0] next_ff, next_in;
   logic [HANDLE_WIDTH-1:0] stack_mem [CAPACITY];
   logic [HANDLE_WIDTH-1:0] pop_ff;
   logic out_v_ff;
   logic fin_live_ff, fin_on_ff;
   logic [IW-1:0] fin_idx_ff;
   logic push;

   logic [IW-1:0] addr;
   logic [HANDLE_WIDTH-1:0] key;
   logic found;
   logic [IW-1:0] found_idx;
   logic sel_live, sel_on;
   logic req_fire, is_pop, is_fresh, walk_more, trig;
   logic [PW-1:0] lhs, rhs;

   assign req.ready = (state_ff == S_IDLE) && !out_v_ff;
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= THR_W'(128);
      else if (csr.valid) thr_ff <= csr.data;
   end

   assign is_pop    = (rq_ff == REQ_ALLOC) && (depth_ff != '0);
   assign is_fresh  = (rq_ff == REQ_ALLOC) && (depth_ff == '0);
   // compaction walks rd over slots; a dead slot at rd is removed by shifting
   // every cell at rd and above down one place
   assign walk_more = rd_ff < used_ff;

   // search the popped candidate for a reuse, else the request handle
   assign key = (state_ff == S_SEARCH && is_pop) ? pop_ff : h_ff;

   // freed*256 >= thr*used after the free
   assign lhs  = PW'({freed_ff + CW'(1), 8'd0});
   assign rhs  = PW'(thr_ff) * PW'(used_ff);
   assign trig = (used_ff != '0) && (lhs >= rhs);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_fire) state_in = S_SEARCH;
         S_SEARCH:  state_in = S_APPLY;
         S_APPLY:   state_in = comp_in ? S_COMPACT : S_LOOK;
         S_COMPACT: if (!walk_more) state_in = S_LOOK;
         S_LOOK:    state_in = S_FINAL;
         S_FINAL:   state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // cell controls and counter updates per state
   always_comb begin
      ctl = '0;
      push = 1'b0;
      addr = IW'(used_ff);
      h_in = h_ff; st_in = st_ff; comp_in = comp_ff;
      used_in = used_ff; freed_in = freed_ff; depth_in = depth_ff;
      on_in = on_ff; rd_in = rd_ff; next_in = next_ff;
      case (state_ff)
         S_IDLE: if (req_fire) begin
            h_in = HANDLE_WIDTH'(req.data.obj_handle);
            comp_in = 1'b0;
         end
         S_SEARCH: ctl.search = 1'b1;
         S_APPLY: begin
            rd_in = '0;
            addr = is_fresh ? IW'(used_ff) : found_idx;
            case (rq_ff)
               REQ_ALLOC: begin
                  if (depth_ff != '0) begin
                     // consume the top reuse entry whatever it holds
                     depth_in = depth_ff - CW'(1);
                     if (found && !sel_live) begin
                        st_in = ST_OK; h_in = pop_ff;
                        ctl.set_live = 1'b1; ctl.set_on = 1'b1;
                        on_in = on_ff + CW'(1);
                        if (freed_ff != '0) freed_in = freed_ff - CW'(1);
                     end else begin
                        st_in = ST_CORRUPT; h_in = '0;
                     end
                  end else if (used_ff >= CW'(CAPACITY) || next_ff == '0) begin
                     st_in = ST_FULL; h_in = '0;
                  end else begin
                     st_in = ST_OK; h_in = next_ff;
                     next_in = next_ff + HANDLE_WIDTH'(1);
                     ctl.write_new = 1'b1; ctl.set_live = 1'b1; ctl.set_on = 1'b1;
                     used_in = used_ff + CW'(1);
                     on_in = on_ff + CW'(1);
                  end
               end
               REQ_FREE, REQ_ACT, REQ_DEACT, REQ_QUERY: begin
                  if (h_ff == '0) st_in = ST_INVALID;
                  else if (!found) st_in = ST_UNKNOWN;
                  else if (!sel_live) st_in = ST_NOT_ALLOC;
                  else begin
                     st_in = ST_OK;
                     case (rq_ff)
                        REQ_FREE: begin
                           if (sel_on && on_ff != '0) on_in = on_ff - CW'(1);
                           ctl.clr_live = 1'b1; ctl.clr_on = 1'b1;
                           if (depth_ff < CW'(CAPACITY)) begin
                              push = 1'b1;
                              depth_in = depth_ff + CW'(1);
                           end
                           freed_in = freed_ff + CW'(1);
                           comp_in = trig;
                        end
                        REQ_ACT: begin
                           if (sel_on) st_in = ST_NO_CHANGE;
                           else begin
                              ctl.set_on = 1'b1;
                              on_in = on_ff + CW'(1);
                           end
                        end
                        REQ_DEACT: begin
                           if (!sel_on) st_in = ST_NO_CHANGE;
                           else begin
                              ctl.clr_on = 1'b1;
                              if (on_ff != '0) on_in = on_ff - CW'(1);
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               REQ_COMPACT: begin
                  if (freed_ff != '0) begin
                     st_in = ST_OK; comp_in = 1'b1;
                  end else begin
                     st_in = ST_NO_CHANGE;
                  end
               end
               default: st_in = ST_NO_CHANGE;
            endcase
         end
         S_COMPACT: begin
            addr = IW'(rd_ff);
            if (walk_more) begin
               // drop a dead slot by shifting down, else advance
               if (!sel_live) begin
                  ctl.shift = 1'b1;
                  used_in = used_ff - CW'(1);
               end else begin
                  rd_in = rd_ff + CW'(1);
               end
            end else begin
               ctl.clear_all = 1'b1;
               freed_in = '0; depth_in = '0;
            end
         end
         S_LOOK: ctl.search = 1'b1;
         S_FINAL: addr = found_idx;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_v_ff <= 1'b0;
         used_ff <= '0; freed_ff <= '0; depth_ff <= '0; on_ff <= '0;
         next_ff <= HANDLE_WIDTH'(1); comp_ff <= 1'b0; rd_ff <= '0;
         h_ff <= '0; st_ff <= ST_OK;
         fin_live_ff <= 1'b0; fin_on_ff <= 1'b0; fin_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         h_ff <= h_in; st_ff <= st_in; comp_ff <= comp_in;
         used_ff <= used_in; freed_ff <= freed_in; depth_ff <= depth_in;
         on_ff <= on_in; rd_ff <= rd_in; next_ff <= next_in;
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         else if (state_ff == S_FINAL) out_v_ff <= 1'b1;
         // hold the final lookup for the result beat
         if (state_ff == S_FINAL) begin
            fin_idx_ff  <= found ? found_idx : '0;
            fin_live_ff <= found && sel_live;
            fin_on_ff   <= found && sel_live && sel_on;
         end
      end
   end

   // request capture and reuse stack: read the top on accept, push on free
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rq_ff <= req.data.req_type;
         if (depth_ff != '0) pop_ff <= stack_mem[IW'(depth_ff - CW'(1))];
      end
      if (push) stack_mem[IW'(depth_ff)] <= h_ff;
   end

   sha_chain #(.CAP(CAPACITY), .HW(HANDLE_WIDTH)) u_chain (
      .clock, .reset, .ctl,
      .addr, .bound(used_ff), .hole(IW'(rd_ff)), .key, .wr_handle(next_ff),
      .found, .found_idx, .sel_live, .sel_on
   );

   always_comb begin
      rsp.valid = out_v_ff;
      rsp.data.status        = st_ff;
      rsp.data.result_handle = OBJ_W'(h_ff);
      rsp.data.slot_index    = SLOT_W'(fin_idx_ff);
      rsp.data.is_allocated  = fin_live_ff;
      rsp.data.is_active     = fin_on_ff;
      rsp.data.active_count  = CNT_W'(on_ff);
      rsp.data.compacted     = comp_ff;
   end
endmodule

>>> rtl/sha_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on sha_pkg and the defines header.
`include "slot_handle_allocator_compacting_core_defines.svh"
module sha_port_checker import sha_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic rsp_alloc,
   input logic rsp_active
);
   `SHA_ASSERT_IMPL(a_active_needs_alloc, clock, reset, rsp_valid && rsp_active, rsp_alloc)
   `SHA_ASSERT_IMPL(a_no_accept_while_out, clock, reset, rsp_valid, !req_ready)
   `SHA_ASSERT_NEXT(a_accept_no_rsp, clock, reset, req_valid && req_ready, !rsp_valid)
   `SHA_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status != 3'd7)
endmodule

bind slot_handle_allocator_compacting_core sha_port_checker u_sha_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status), .rsp_alloc(rsp.data.is_allocated),
   .rsp_active(rsp.data.is_active)
);
